@@ hdl/smwd_pkg.sv @@
`default_nettype none

package smwd_pkg;

  localparam int PIX_W  = 8;
  localparam int ROWS_W = 14;
  localparam int COLS_W = 11;
  localparam int HALF_W = 4;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [PIX_W-1:0]  DILATED_VALUE = 8'd254;
  localparam logic [ROWS_W-1:0] ROWS_RST      = 14'd1;
  localparam logic [COLS_W-1:0] COLS_RST      = 11'd1;
  localparam logic [HALF_W-1:0] HALF_RST      = 4'd0;
  localparam logic [PIX_W-1:0]  FILL_RST      = 8'd255;

  typedef enum logic [2:0] {
    REG_NUM_ROWS,
    REG_NUM_COLS,
    REG_HALF_WINDOW,
    REG_FILL_VALUE,
    REG_SEED_W0,
    REG_SEED_W1,
    REG_SEED_W2,
    REG_SEED_W3
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             drain;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             image_last;
  } rsp_t;

  // One stored pixel: its seed flag is resolved when it is written.
  typedef struct packed {
    logic             seed;
    logic [PIX_W-1:0] value;
  } store_t;

  // One window column: near is the seed flag ORed down the window rows.
  typedef struct packed {
    logic             near;
    logic             seed;
    logic [PIX_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

@@ hdl/smwd_bank.sv @@
`default_nettype none

module smwd_bank
  import smwd_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  store_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output store_t            rdata
);

  store_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/smwd_cell.sv @@
`default_nettype none

module smwd_cell
  import smwd_pkg::*;
#(
  parameter int J      = 0,
  parameter int COL_W  = 11,
  parameter int CIDX_W = 10,
  parameter int HW_W   = 4
) (
  input  logic              clk,
  input  logic              shift,
  input  entry_t            din,
  output entry_t            dout,
  input  logic [CIDX_W-1:0] kcol,
  input  logic [HW_W-1:0]   hw,
  input  logic [COL_W-1:0]  cols,
  output logic              hit
);

  localparam int W = COL_W + HW_W + 1;

  logic [W-1:0] pos;
  logic [W-1:0] jw;

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

  // This cell holds the column at kcol + hw - J; it counts only inside the
  // window and inside the output pixel's own row.
  assign pos = W'(kcol) + W'(hw);
  assign jw  = W'(J);
  assign hit = dout.near && (jw <= (W'(hw) << 1)) && (pos >= jw) && (pos < W'(cols) + jw);

endmodule

`default_nettype wire

@@ hdl/seed_mask_window_dilation_unit.sv @@
`default_nettype none

// Channel   Payload  Handshake             Carries
// request   req      req_valid/req_stall   mask pixel or drain marker
// result    rsp      rsp_valid/rsp_stall   dilated pixel and image end flag
// config    APB      psel/penable/pwrite   registers at byte address 8*index
//
// Sustained rate is one pixel per cycle while neither side stalls; a result
// leaves through the bank read, the window chain and the output register.
// Requests stall while a new pixel would overwrite a row bank the window
// still reads, and at the start of a new image until the previous one is out.
// Reset is synchronous; rst clears control state and loads register defaults.

module seed_mask_window_dilation_unit
  import smwd_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_HALF = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp
);

  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int HW_W   = $clog2(MAX_HALF + 1);
  localparam int NBANK  = 2 * MAX_HALF + 2;
  localparam int BANK_W = $clog2(NBANK);
  localparam int NCELL  = 2 * MAX_HALF + 1;
  localparam int CELL_W = $clog2(NCELL);
  localparam int ERW    = ROWS_W + 1;
  localparam int LIN_W  = ROWS_W + COL_W + 1;

  // Configuration registers.
  logic [ROWS_W-1:0]    num_rows;
  logic [COLS_W-1:0]    num_cols;
  logic [HALF_W-1:0]    half_window;
  logic [PIX_W-1:0]     fill_value;
  logic [3:0][DATA_W-1:0] seed_w;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  logic [ROWS_W-1:0] rows_eff;
  logic [COL_W-1:0]  cols_eff;
  logic [HW_W-1:0]   hw_eff;
  logic [LIN_W-1:0]  npix;
  logic [LIN_W-1:0]  hwc;
  logic [LIN_W-1:0]  hw_lin;

  // Input side bookkeeping, in step with the request stream.
  logic [LIN_W-1:0]  in_lin;
  logic [CIDX_W-1:0] in_col;
  logic [ERW-1:0]    in_row;
  logic [BANK_W-1:0] in_bank;
  logic [LIN_W-1:0]  out_lin_m;
  logic [LIN_W-1:0]  owed;
  logic              eng_done;

  logic             acc;
  logic             in_done;
  logic             is_pix;
  logic [LIN_W-1:0] in_lin_a;
  logic             done_a;
  logic             emit;
  logic             last_m;
  logic             ring_block;
  logic             new_block;
  logic             seed_in;

  // Window engine.
  logic [LIN_W-1:0]  e_lin;
  logic [CIDX_W-1:0] ecol;
  logic [ERW-1:0]    erow;
  logic [BANK_W-1:0] ebank;
  logic [LIN_W-1:0]  chain_cnt;
  logic [LIN_W-1:0]  k_lin;
  logic [CIDX_W-1:0] kcol;
  logic              s1_valid;
  logic [NBANK-1:0]  s1_mask;
  logic [BANK_W-1:0] s1_cbank;

  logic ready_e;
  logic full;
  logic fire;
  logic eng_last;
  logic s1_adv;
  logic s0_go;

  logic [NBANK-1:0] win;
  logic [NBANK-1:0] q_seed;
  store_t           bank_q [NBANK];
  entry_t           s1_entry;
  entry_t           cell_q [NCELL];
  logic [NCELL-1:0] hits;
  entry_t           center;
  logic             dil;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows    <= ROWS_RST;
      num_cols    <= COLS_RST;
      half_window <= HALF_RST;
      fill_value  <= FILL_RST;
      seed_w      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NUM_ROWS:    num_rows    <= pwdata[ROWS_W-1:0];
        REG_NUM_COLS:    num_cols    <= pwdata[COLS_W-1:0];
        REG_HALF_WINDOW: half_window <= pwdata[HALF_W-1:0];
        REG_FILL_VALUE:  fill_value  <= pwdata[PIX_W-1:0];
        REG_SEED_W0:     seed_w[0]   <= pwdata;
        REG_SEED_W1:     seed_w[1]   <= pwdata;
        REG_SEED_W2:     seed_w[2]   <= pwdata;
        REG_SEED_W3:     seed_w[3]   <= pwdata;
        default:         num_rows    <= num_rows;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NUM_ROWS:    prdata = DATA_W'(num_rows);
      REG_NUM_COLS:    prdata = DATA_W'(num_cols);
      REG_HALF_WINDOW: prdata = DATA_W'(half_window);
      REG_FILL_VALUE:  prdata = DATA_W'(fill_value);
      REG_SEED_W0:     prdata = seed_w[0];
      REG_SEED_W1:     prdata = seed_w[1];
      REG_SEED_W2:     prdata = seed_w[2];
      REG_SEED_W3:     prdata = seed_w[3];
      default:         prdata = '0;
    endcase
  end

  // Out-of-range settings are clamped to the nearest legal value.
  always_comb begin
    rows_eff = (num_rows == '0) ? ROWS_W'(1) : num_rows;
    if (num_cols == '0) begin
      cols_eff = COL_W'(1);
    end else if (int'(num_cols) > MAX_COLS) begin
      cols_eff = COL_W'(MAX_COLS);
    end else begin
      cols_eff = COL_W'(num_cols);
    end
    hw_eff = (int'(half_window) > MAX_HALF) ? HW_W'(MAX_HALF) : HW_W'(half_window);
  end

  assign npix   = LIN_W'(rows_eff) * LIN_W'(cols_eff);
  assign hwc    = LIN_W'(hw_eff) * LIN_W'(cols_eff);
  assign hw_lin = LIN_W'(hw_eff);

  // Request side: decide per request whether it stores a pixel and whether
  // it releases the next result.
  assign in_done  = (in_lin == npix);
  assign is_pix   = !req.drain && !in_done;
  assign in_lin_a = in_lin + LIN_W'(is_pix);
  assign done_a   = (in_lin_a == npix);
  assign acc      = req_valid && !req_stall;
  assign emit     = acc && (is_pix || in_done) &&
                    (done_a || (in_lin_a > out_lin_m + hwc + hw_lin));
  assign last_m   = emit && (out_lin_m == npix - LIN_W'(1));
  assign seed_in  = seed_w[req.pixel_in[7:6]][req.pixel_in[5:0]];

  assign ring_block = ((ERW+1)'(in_row) + (ERW+1)'(hw_eff)) >=
                      ((ERW+1)'(erow) + (ERW+1)'(NBANK));
  assign new_block  = (in_lin == '0) && ((owed != '0) || (k_lin != '0));
  assign req_stall  = ring_block || new_block;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_lin    <= '0;
      in_col    <= '0;
      in_row    <= '0;
      in_bank   <= '0;
      out_lin_m <= '0;
    end else if (acc) begin
      if (last_m) begin
        in_lin    <= '0;
        in_col    <= '0;
        in_row    <= '0;
        in_bank   <= '0;
        out_lin_m <= '0;
      end else begin
        if (is_pix) begin
          in_lin <= in_lin_a;
          if (COL_W'(in_col) == cols_eff - COL_W'(1)) begin
            in_col  <= '0;
            in_row  <= in_row + ERW'(1);
            in_bank <= (in_bank == BANK_W'(NBANK - 1)) ? '0 : in_bank + BANK_W'(1);
          end else begin
            in_col <= in_col + CIDX_W'(1);
          end
        end
        if (emit) begin
          out_lin_m <= out_lin_m + LIN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      owed     <= '0;
      eng_done <= 1'b0;
    end else begin
      owed <= owed + LIN_W'(emit) - LIN_W'(fire);
      if (eng_last) begin
        eng_done <= 1'b0;
      end else if (acc && is_pix && done_a) begin
        eng_done <= 1'b1;
      end
    end
  end

  // Engine: a column enters once the bottom row of its window is stored.
  assign ready_e  = eng_done || (in_lin > e_lin + hwc);
  assign full     = (chain_cnt == k_lin + hw_lin + LIN_W'(1));
  assign fire     = (owed != '0) && full && (!rsp_valid || !rsp_stall);
  assign eng_last = fire && (k_lin == npix - LIN_W'(1));
  assign s1_adv   = s1_valid && (!full || fire);
  assign s0_go    = ready_e && (!s1_valid || s1_adv) && !eng_last;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr || eng_last) begin
      e_lin     <= '0;
      ecol      <= '0;
      erow      <= '0;
      ebank     <= '0;
      chain_cnt <= '0;
      k_lin     <= '0;
      kcol      <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (s0_go) begin
        e_lin <= e_lin + LIN_W'(1);
        if (COL_W'(ecol) == cols_eff - COL_W'(1)) begin
          ecol  <= '0;
          erow  <= erow + ERW'(1);
          ebank <= (ebank == BANK_W'(NBANK - 1)) ? '0 : ebank + BANK_W'(1);
        end else begin
          ecol <= ecol + CIDX_W'(1);
        end
      end
      if (s1_adv) begin
        chain_cnt <= chain_cnt + LIN_W'(1);
      end
      if (fire) begin
        k_lin <= k_lin + LIN_W'(1);
        kcol  <= (COL_W'(kcol) == cols_eff - COL_W'(1)) ? '0 : kcol + CIDX_W'(1);
      end
      if (s0_go) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go) begin
      s1_mask  <= win;
      s1_cbank <= ebank;
    end
  end

  // Row banks: bank b holds every image row whose index is b modulo NBANK.
  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [BANK_W:0] rel;

    always_comb begin
      if (BANK_W'(b) >= ebank) begin
        rel = (BANK_W+1)'(b) - (BANK_W+1)'(ebank);
      end else begin
        rel = (BANK_W+1)'(b + NBANK) - (BANK_W+1)'(ebank);
      end
      win[b] = ((rel <= (BANK_W+1)'(hw_eff)) &&
                ((ERW+1)'(erow) + (ERW+1)'(rel) < (ERW+1)'(rows_eff))) ||
               ((rel >= (BANK_W+1)'(NBANK) - (BANK_W+1)'(hw_eff)) &&
                ((ERW+1)'(NBANK) - (ERW+1)'(rel) <= (ERW+1)'(erow)));
    end

    smwd_bank #(
      .DEPTH  (MAX_COLS),
      .ADDR_W (CIDX_W)
    ) u_bank (
      .clk   (clk),
      .we    (acc && is_pix && (in_bank == BANK_W'(b))),
      .waddr (in_col),
      .wdata ({seed_in, req.pixel_in}),
      .re    (s0_go),
      .raddr (ecol),
      .rdata (bank_q[b])
    );

    assign q_seed[b] = bank_q[b].seed;
  end

  assign s1_entry.near  = |(s1_mask & q_seed);
  assign s1_entry.seed  = bank_q[s1_cbank].seed;
  assign s1_entry.value = bank_q[s1_cbank].value;

  // Horizontal window: cell 0 takes the newest column, cell hw is the center.
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    smwd_cell #(
      .J      (j),
      .COL_W  (COL_W),
      .CIDX_W (CIDX_W),
      .HW_W   (HW_W)
    ) u_cell (
      .clk   (clk),
      .shift (s1_adv),
      .din   ((j == 0) ? s1_entry : cell_q[(j == 0) ? 0 : j - 1]),
      .dout  (cell_q[j]),
      .kcol  (kcol),
      .hw    (hw_eff),
      .cols  (cols_eff),
      .hit   (hits[j])
    );
  end

  assign center = cell_q[CELL_W'(hw_eff)];
  assign dil    = (center.value != fill_value) && !center.seed && (|hits);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.pixel_out  <= dil ? DILATED_VALUE : center.value;
      rsp.image_last <= (k_lin == npix - LIN_W'(1));
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_seed_mask_window_dilation_unit.sv @@
`default_nettype none

module tb_seed_mask_window_dilation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import smwd_pkg::*;

  localparam int MAXC = 1024;
  localparam int MAXH = 8;
  localparam int HIST = (2 * MAXH + 2) * (MAXC + 1);
  localparam int CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  seed_mask_window_dilation_unit DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [7:0] pix_hist [HIST];
  int unsigned m_rows, m_cols, m_half, m_fill;
  logic [63:0] m_seed [4];
  int unsigned in_r, in_c, out_r, out_c;

  req_t pending_reqs[$];
  rsp_t dilated_q[$];
  int errors = 0;
  int cycles = 0;
  logic long_hold = 1'b0;
  logic calm = 1'b0;

  function automatic logic seed_of(int unsigned v);
    return m_seed[(v >> 6) & 3][v & 63];
  endfunction

  function automatic logic [7:0] hist_at(int unsigned r, int unsigned c, int unsigned cols);
    return pix_hist[(r * cols + c) % HIST];
  endfunction

  task automatic restart_image();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
  endtask

  task automatic predict_dilation(input req_t it);
    int unsigned rows, cols, hw, in_k, out_k, v, res, r0, r1, c0, c1;
    logic in_done, found;
    rsp_t o;
    rows = (m_rows == 0) ? 1 : m_rows;
    cols = (m_cols == 0) ? 1 : ((m_cols > MAXC) ? MAXC : m_cols);
    hw = (m_half > MAXH) ? MAXH : m_half;
    in_done = (in_r >= rows);
    found = 1'b0;
    if (!it.drain && !in_done) begin
      pix_hist[(in_r * cols + in_c) % HIST] = it.pixel_in;
      in_c++;
      if (in_c >= cols) begin
        in_c = 0;
        in_r++;
      end
    end else if (!in_done) begin
      return;
    end
    in_done = (in_r >= rows);
    in_k = in_r * cols + in_c;
    out_k = out_r * cols + out_c;
    if (out_r >= rows) return;
    if (!in_done && in_k <= out_k + hw * cols + hw) return;
    v = hist_at(out_r, out_c, cols);
    res = v;
    if (v != m_fill && !seed_of(v)) begin
      r0 = (out_r >= hw) ? out_r - hw : 0;
      r1 = (out_r + hw >= rows) ? rows - 1 : out_r + hw;
      c0 = (out_c >= hw) ? out_c - hw : 0;
      c1 = (out_c + hw >= cols) ? cols - 1 : out_c + hw;
      for (int unsigned r = r0; r <= r1; r++)
        for (int unsigned c = c0; c <= c1; c++)
          if (seed_of(hist_at(r, c, cols))) found = 1'b1;
      if (found) res = DILATED_VALUE;
    end
    o.pixel_out = res[7:0];
    o.image_last = (out_r == rows - 1 && out_c == cols - 1);
    dilated_q.push_back(o);
    out_c++;
    if (out_c >= cols) begin
      out_c = 0;
      out_r++;
    end
    if (o.image_last) restart_image();
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Driver: offers the pending requests in order with random idle bursts.
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predict_dilation(req);
        void'(pending_reqs.pop_front());
      end
      if (req_valid && req_stall) begin
        // keep the stalled request unchanged
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (!calm && !long_hold && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(1, 9) - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_valid <= 1'b1;
        req <= pending_reqs[0];
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  int stall_left = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (dilated_q.size() == 0) begin
          report_mismatch("unexpected result", rsp.pixel_out, -1);
        end else begin
          if (rsp.pixel_out !== dilated_q[0].pixel_out)
            report_mismatch("pixel_out", rsp.pixel_out, dilated_q[0].pixel_out);
          if (rsp.image_last !== dilated_q[0].image_last)
            report_mismatch("image_last", rsp.image_last, dilated_q[0].image_last);
          void'(dilated_q.pop_front());
        end
      end
      if (long_hold) begin
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 9) - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(8 * int'(idx)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_NUM_ROWS: m_rows = val[13:0];
      REG_NUM_COLS: m_cols = val[10:0];
      REG_HALF_WINDOW: m_half = val[3:0];
      REG_FILL_VALUE: m_fill = val[7:0];
      default: m_seed[int'(idx) - int'(REG_SEED_W0)] = val;
    endcase
    restart_image();
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || req_valid || dilated_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_pixel();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 3) return 8'(m_fill);
    if (k < 6) return 8'($urandom_range(0, 15));
    return 8'($urandom);
  endfunction

  // Queues one full image of random content, drains and some noise.
  task automatic queue_image(input int unsigned rows, input int unsigned cols);
    req_t it;
    int unsigned rr, cc, hh, lag, tail;
    rr = (rows == 0) ? 1 : rows;
    cc = (cols == 0) ? 1 : ((cols > MAXC) ? MAXC : cols);
    hh = (m_half > MAXH) ? MAXH : m_half;
    lag = hh * cc + hh;
    // The tail is just long enough to flush the results still owed.
    tail = ((rr * cc < lag) ? rr * cc : lag) + 2;
    for (int unsigned i = 0; i < rr * cc; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        it.drain = 1'b1; it.pixel_in = 8'($urandom);
        pending_reqs.push_back(it);
      end
      it.drain = 1'b0; it.pixel_in = rand_pixel();
      pending_reqs.push_back(it);
    end
    for (int unsigned i = 0; i < tail; i++) begin
      it.drain = ($urandom_range(0, 7) != 0); it.pixel_in = 8'($urandom);
      pending_reqs.push_back(it);
    end
  endtask

  task automatic phase(input int unsigned rows, input int unsigned cols,
                       input int unsigned hw, input int unsigned fill,
                       input int unsigned images);
    write_reg(REG_NUM_ROWS, 64'(rows));
    write_reg(REG_NUM_COLS, 64'(cols));
    write_reg(REG_HALF_WINDOW, 64'(hw));
    write_reg(REG_FILL_VALUE, 64'(fill));
    for (int w = 0; w < 4; w++)
      write_reg(reg_idx_t'(int'(REG_SEED_W0) + w),
                ($urandom_range(0, 3) == 0) ? '1 : {$urandom, $urandom} & {$urandom, $urandom});
    for (int i = 0; i < images; i++) queue_image(rows, cols);
    wait_idle();
  endtask

  initial begin
    req_t it;
    logic [7:0] tiny_img [12];
    m_rows = ROWS_RST; m_cols = COLS_RST; m_half = HALF_RST; m_fill = FILL_RST;
    for (int w = 0; w < 4; w++) m_seed[w] = '0;
    foreach (pix_hist[i]) pix_hist[i] = '0;
    restart_image();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: reset settings, extreme pixels, a drain before image end.
    it.drain = 1'b1; it.pixel_in = 8'hFF; pending_reqs.push_back(it);
    it.drain = 1'b0; it.pixel_in = 8'h00; pending_reqs.push_back(it);
    it.pixel_in = 8'hFF; pending_reqs.push_back(it);
    it.drain = 1'b1; it.pixel_in = 8'h00; pending_reqs.push_back(it);
    wait_idle();
    // Zero sizes, oversize window, a small dilation image.
    write_reg(REG_NUM_ROWS, 64'd0);
    write_reg(REG_NUM_COLS, 64'd0);
    write_reg(REG_HALF_WINDOW, 64'd15);
    write_reg(REG_FILL_VALUE, 64'd0);
    write_reg(REG_SEED_W0, 64'h2);
    write_reg(REG_SEED_W1, '0);
    write_reg(REG_SEED_W2, '0);
    write_reg(REG_SEED_W3, 64'h8000_0000_0000_0000);
    for (int i = 0; i < 6; i++) begin
      it.drain = 1'b0; it.pixel_in = 8'(i * 51); pending_reqs.push_back(it);
    end
    wait_idle();
    write_reg(REG_NUM_ROWS, 64'd3);
    write_reg(REG_NUM_COLS, 64'd4);
    write_reg(REG_HALF_WINDOW, 64'd1);
    tiny_img = '{8'd1, 8'd3, 8'd0, 8'd7, 8'd255, 8'd1, 8'd9, 8'd254, 8'd127,
                 8'd128, 8'd3, 8'd1};
    foreach (tiny_img[i]) begin
      it.drain = 1'b0;
      it.pixel_in = tiny_img[i];
      pending_reqs.push_back(it);
    end
    for (int i = 0; i < 4; i++) begin
      it.drain = 1'b1; it.pixel_in = 8'hAA; pending_reqs.push_back(it);
    end
    wait_idle();

    // Long receiver hold so the block fills and stalls its requests.
    write_reg(REG_NUM_ROWS, 64'd24);
    write_reg(REG_NUM_COLS, 64'd8);
    write_reg(REG_HALF_WINDOW, 64'd2);
    long_hold <= 1'b1;
    queue_image(24, 8);
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
    wait_idle();

    phase(8, 8, 0, 255, 2);
    phase(9, 7, 3, 0, 2);
    phase(1, 40, 8, 200, 1);
    phase(20, 2, 8, 17, 1);
    phase(2, 30, 4, 255, 2);
    phase(8192, 1, 2, 5, 0);
    // Oversize column count with an image that is left unfinished.
    write_reg(REG_NUM_ROWS, 64'd1);
    write_reg(REG_NUM_COLS, 64'd2047);
    write_reg(REG_HALF_WINDOW, 64'd0);
    for (int i = 0; i < 100; i++) begin
      it.drain = 1'b0; it.pixel_in = rand_pixel(); pending_reqs.push_back(it);
    end
    wait_idle();
    calm <= 1'b1;
    phase(6, 11, 5, 9, 2);

    repeat (50) @(posedge clk);
    if (errors == 0 && dilated_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
